FILE: hdl/dda_pkg.sv
// Shared types and constants for the decimal digit ALU.
`default_nettype none

package dda_pkg;

    localparam int DIGIT_W       = 4;
    localparam int MAX_DIGITS    = 9;
    localparam int RESULT_DIGITS = 10;
    localparam int OPERAND_W     = MAX_DIGITS * DIGIT_W;
    localparam int RESULT_W      = RESULT_DIGITS * DIGIT_W;
    localparam int LEN_W         = 4;
    localparam int DATA_W        = 32;
    localparam int STEP_W        = $clog2(DATA_W);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_WEIGH = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_NEG   = 7'b0010000,
        ST_CONV  = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic              sub;
    } addsub_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic              carry;
    } addsub_out_t;

endpackage

`default_nettype wire

FILE: hdl/dda_addsub.sv
// Shared 32-bit adder/subtractor used by add, subtract, divide and negate steps.
`default_nettype none

module dda_addsub (
    input  wire dda_pkg::addsub_in_t op_in,
    output dda_pkg::addsub_out_t     op_out
);
    import dda_pkg::*;

    logic [DATA_W:0] total;

    // carry out set on subtract means no borrow (x >= y)
    assign total = {1'b0, op_in.x}
                 + {1'b0, (op_in.sub ? ~op_in.y : op_in.y)}
                 + {{DATA_W{1'b0}}, op_in.sub};

    assign op_out.sum   = total[DATA_W-1:0];
    assign op_out.carry = total[DATA_W];

endmodule

`default_nettype wire

FILE: hdl/decimal_digit_alu.sv
// Decimal digit ALU: weigh two digit operands, add/sub/mul/div, convert back to digits.
// Throughput: one word at a time; busy is high from acceptance until the strobe.
// A word passes the 9-step digit weighing, for divide the 32-step restoring divide
// on the shared adder, and, but for a zero divisor, the 32-step shift-and-add-3
// conversion. Results cannot be stalled.
// Reset: rst_n asynchronous, active low, returns the sequencer to idle.
`default_nettype none

module decimal_digit_alu (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     opcode,
    input  wire logic [dda_pkg::OPERAND_W-1:0]  a_digits,
    input  wire logic [dda_pkg::LEN_W-1:0]      a_len,
    input  wire logic [dda_pkg::OPERAND_W-1:0]  b_digits,
    input  wire logic [dda_pkg::LEN_W-1:0]      b_len,
    output logic                                done,
    output logic [dda_pkg::RESULT_W-1:0]        result_digits,
    output logic [dda_pkg::LEN_W-1:0]           result_len,
    output logic                                negative,
    output logic                                status
);
    import dda_pkg::*;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [OPERAND_W-1:0]  a_dig_reg, a_dig_next;
    logic [OPERAND_W-1:0]  b_dig_reg, b_dig_next;
    logic [LEN_W-1:0]      a_cnt_reg, a_cnt_next;
    logic [LEN_W-1:0]      b_cnt_reg, b_cnt_next;
    logic [DATA_W-1:0]     a_val_reg, a_val_next;
    logic [DATA_W-1:0]     b_val_reg, b_val_next;
    logic [DATA_W-1:0]     r_reg, r_next;
    logic [DATA_W-1:0]     rem_reg, rem_next;
    logic [RESULT_W-1:0]   bcd_reg, bcd_next;
    logic                  neg_reg, neg_next;
    logic                  done_reg, done_next;
    logic [RESULT_W-1:0]   res_dig_reg, res_dig_next;
    logic [LEN_W-1:0]      res_len_reg, res_len_next;
    logic                  res_neg_reg, res_neg_next;
    logic                  res_stat_reg, res_stat_next;

    addsub_in_t            au_in;
    addsub_out_t           au_out;

    dda_addsub u_addsub (
        .op_in  (au_in),
        .op_out (au_out)
    );

    // Shared unit operand select
    always_comb
    begin
        au_in = '0;
        case (state_reg)
            ST_EXEC:
            begin
                au_in.x   = a_val_reg;
                au_in.y   = b_val_reg;
                au_in.sub = (op_reg == OP_SUB);
            end
            ST_DIV:
            begin
                au_in.x   = {rem_reg[DATA_W-2:0], r_reg[DATA_W-1]};
                au_in.y   = b_val_reg;
                au_in.sub = 1'b1;
            end
            ST_NEG:
            begin
                au_in.x   = '0;
                au_in.y   = r_reg;
                au_in.sub = 1'b1;
            end
            default:
            begin
                au_in = '0;
            end
        endcase
    end

    always_comb
    begin
        logic [DIGIT_W-1:0]    nib_a;
        logic [DIGIT_W-1:0]    nib_b;
        logic [DATA_W-1:0]     prod;
        logic [RESULT_W-1:0]   adj;
        logic [LEN_W-1:0]      len;
        logic [LEN_W-1:0]      idx;

        state_next    = state_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        a_dig_next    = a_dig_reg;
        b_dig_next    = b_dig_reg;
        a_cnt_next    = a_cnt_reg;
        b_cnt_next    = b_cnt_reg;
        a_val_next    = a_val_reg;
        b_val_next    = b_val_reg;
        r_next        = r_reg;
        rem_next      = rem_reg;
        bcd_next      = bcd_reg;
        neg_next      = neg_reg;
        done_next     = 1'b0;
        res_dig_next  = res_dig_reg;
        res_len_next  = res_len_reg;
        res_neg_next  = res_neg_reg;
        res_stat_next = res_stat_reg;

        idx   = cnt_reg[LEN_W-1:0];
        nib_a = (idx < a_cnt_reg) ? a_dig_reg[{idx, 2'b00} +: DIGIT_W] : '0;
        nib_b = (idx < b_cnt_reg) ? b_dig_reg[{idx, 2'b00} +: DIGIT_W] : '0;
        // only the low word of the product is kept
        prod  = a_val_reg * b_val_reg;
        len   = '0;

        // shift-and-add-3: bump each digit of 5 or more before the shift
        adj = bcd_reg;
        for (int k = 0; k < RESULT_DIGITS; k++)
        begin
            if (bcd_reg[k*DIGIT_W +: DIGIT_W] >= 4'd5)
                adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W] + 4'd3;
        end

        for (int k = 0; k < RESULT_DIGITS; k++)
        begin
            if (bcd_reg[k*DIGIT_W +: DIGIT_W] != '0)
                len = LEN_W'(k + 1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = op_t'(opcode);
                    a_dig_next = a_digits;
                    b_dig_next = b_digits;
                    a_cnt_next = (a_len > LEN_W'(MAX_DIGITS)) ? LEN_W'(MAX_DIGITS) : a_len;
                    b_cnt_next = (b_len > LEN_W'(MAX_DIGITS)) ? LEN_W'(MAX_DIGITS) : b_len;
                    a_val_next = '0;
                    b_val_next = '0;
                    cnt_next   = STEP_W'(MAX_DIGITS - 1);
                    state_next = ST_WEIGH;
                end
            end
            ST_WEIGH:
            begin
                // Horner step, most significant digit first: v = 10v + digit
                a_val_next = {a_val_reg[DATA_W-4:0], 3'b000} + {a_val_reg[DATA_W-2:0], 1'b0}
                           + DATA_W'(nib_a);
                b_val_next = {b_val_reg[DATA_W-4:0], 3'b000} + {b_val_reg[DATA_W-2:0], 1'b0}
                           + DATA_W'(nib_b);
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        r_next     = au_out.sum;
                        state_next = ST_NEG;
                    end
                    OP_MUL:
                    begin
                        r_next     = prod;
                        state_next = ST_NEG;
                    end
                    default:
                    begin
                        if (b_val_reg == '0)
                        begin
                            res_dig_next  = '0;
                            res_len_next  = '0;
                            res_neg_next  = 1'b0;
                            res_stat_next = STATUS_DIV_ZERO;
                            done_next     = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            r_next     = a_val_reg;
                            rem_next   = '0;
                            cnt_next   = STEP_W'(DATA_W - 1);
                            state_next = ST_DIV;
                        end
                    end
                endcase
            end
            ST_DIV:
            begin
                // restoring step; quotient bits shift into r_reg from the right
                rem_next = au_out.carry ? au_out.sum
                                        : {rem_reg[DATA_W-2:0], r_reg[DATA_W-1]};
                r_next   = {r_reg[DATA_W-2:0], au_out.carry};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_NEG;
            end
            ST_NEG:
            begin
                neg_next   = r_reg[DATA_W-1];
                if (r_reg[DATA_W-1])
                    r_next = au_out.sum;
                bcd_next   = '0;
                cnt_next   = STEP_W'(DATA_W - 1);
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                {bcd_next, r_next} = {adj[RESULT_W-2:0], r_reg, 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                res_dig_next  = bcd_reg;
                res_len_next  = len;
                res_neg_next  = neg_reg;
                res_stat_next = STATUS_OK;
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cnt_reg      <= cnt_next;
        a_dig_reg    <= a_dig_next;
        b_dig_reg    <= b_dig_next;
        a_cnt_reg    <= a_cnt_next;
        b_cnt_reg    <= b_cnt_next;
        a_val_reg    <= a_val_next;
        b_val_reg    <= b_val_next;
        r_reg        <= r_next;
        rem_reg      <= rem_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        res_dig_reg  <= res_dig_next;
        res_len_reg  <= res_len_next;
        res_neg_reg  <= res_neg_next;
        res_stat_reg <= res_stat_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign result_digits = res_dig_reg;
    assign result_len    = res_len_reg;
    assign negative      = res_neg_reg;
    assign status        = res_stat_reg;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word strobed while sequencer busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not start the sequencer");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (result_digits == '0 && result_len == '0 && !negative))
        else $error("divide by zero word carries digits");

    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !status && result_len == '0) |-> (result_digits == '0 && !negative))
        else $error("zero length result with nonzero digits or sign");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the decimal digit ALU: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import dda_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 120;
    localparam int RAND_WORDS  = 630;

    typedef struct {
        logic [RESULT_W-1:0] digits;
        logic [LEN_W-1:0]    len;
        logic                neg;
        logic                status;
    } alu_result_t;

    // Predicts each result from the accepted operands and checks the strobed words in order.
    class alu_result_checker;
        alu_result_t awaited_results[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function logic [DATA_W-1:0] operand_value(logic [OPERAND_W-1:0] digits,
                                                  logic [LEN_W-1:0] len);
            logic [DATA_W-1:0] value;
            logic [DATA_W-1:0] weight;
            int                count;
            value  = '0;
            weight = DATA_W'(1);
            count  = (len > MAX_DIGITS) ? MAX_DIGITS : int'(len);
            for (int i = 0; i < count; i++)
            begin
                value  = value + weight * DATA_W'(digits[DIGIT_W*i +: DIGIT_W]);
                weight = weight * 10;
            end
            return value;
        endfunction

        function alu_result_t compute_result(op_t op, logic [DATA_W-1:0] a,
                                             logic [DATA_W-1:0] b);
            alu_result_t       res;
            logic [DATA_W-1:0] r;
            logic [DATA_W-1:0] mag;
            logic [3:0]        digit;
            res.digits = '0;
            res.len    = '0;
            res.neg    = 1'b0;
            res.status = STATUS_OK;
            case (op)
                OP_ADD: r = a + b;
                OP_SUB: r = a - b;
                OP_MUL: r = a * b;
                default:
                begin
                    if (b == 0)
                    begin
                        res.status = STATUS_DIV_ZERO;
                        return res;
                    end
                    r = a / b;
                end
            endcase
            res.neg = r[DATA_W-1];
            mag     = res.neg ? (0 - r) : r;
            for (int k = 0; k < RESULT_DIGITS; k++)
            begin
                digit = 4'(mag % 10);
                res.digits[DIGIT_W*k +: DIGIT_W] = digit;
                mag = mag / 10;
                if (digit != 0 || mag != 0)
                    res.len = LEN_W'(k + 1);
                if (mag == 0)
                    break;
            end
            return res;
        endfunction

        function void note_operands(op_t op, logic [OPERAND_W-1:0] a_dig, logic [LEN_W-1:0] a_n,
                                    logic [OPERAND_W-1:0] b_dig, logic [LEN_W-1:0] b_n);
            awaited_results.push_back(compute_result(op, operand_value(a_dig, a_n),
                                                     operand_value(b_dig, b_n)));
        endfunction

        function void check_result(alu_result_t got);
            alu_result_t want;
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result word digits=%h len=%0d neg=%b status=%b",
                             got.digits, got.len, got.neg, got.status);
                return;
            end
            want = awaited_results.pop_front();
            if (got.digits !== want.digits || got.len !== want.len ||
                got.neg !== want.neg || got.status !== want.status)
            begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: expected digits=%h len=%0d neg=%b status=%b, ",
                              "got digits=%h len=%0d neg=%b status=%b"},
                             want.digits, want.len, want.neg, want.status,
                             got.digits, got.len, got.neg, got.status);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [1:0]           opcode = '0;
    logic [OPERAND_W-1:0] a_digits = '0;
    logic [LEN_W-1:0]     a_len = '0;
    logic [OPERAND_W-1:0] b_digits = '0;
    logic [LEN_W-1:0]     b_len = '0;
    logic                 busy;
    logic                 done;
    logic [RESULT_W-1:0]  result_digits;
    logic [LEN_W-1:0]     result_len;
    logic                 negative;
    logic                 status;

    alu_result_checker checker_h = new();
    int                idle_cycles = 0;
    int                idle_pct = 0;

    decimal_digit_alu dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .a_digits      (a_digits),
        .a_len         (a_len),
        .b_digits      (b_digits),
        .b_len         (b_len),
        .done          (done),
        .result_digits (result_digits),
        .result_len    (result_len),
        .negative      (negative),
        .status        (status)
    );

    always #1 clk = ~clk;

    // Check the strobed word before noting a new one: busy may drop in the strobe cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                checker_h.check_result('{result_digits, result_len, negative, status});
            if (start && !busy)
                checker_h.note_operands(op_t'(opcode), a_digits, a_len, b_digits, b_len);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [OPERAND_W-1:0] to_digits(int v);
        logic [OPERAND_W-1:0] d;
        d = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            d[DIGIT_W*i +: DIGIT_W] = 4'(v % 10);
            v = v / 10;
        end
        return d;
    endfunction

    // Mostly proper decimal digits and legal counts, sometimes raw nibbles or long counts.
    task automatic pick_operand(output logic [OPERAND_W-1:0] digits, output logic [LEN_W-1:0] len);
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
                digits[DIGIT_W*i +: DIGIT_W] = 4'($urandom_range(9));
        end
        else
        begin
            digits = OPERAND_W'({$urandom(), $urandom()});
        end
        sel = $urandom_range(99);
        if (sel < 8)
            len = '0;
        else if (sel < 20)
            len = LEN_W'($urandom_range(15, 10));
        else if (sel < 50)
            len = LEN_W'($urandom_range(3, 1));
        else
            len = LEN_W'($urandom_range(9, 4));
    endtask

    // Present one word, hold it until accepted, then, with probability idle_pct, idle for a random gap.
    task automatic send_word(op_t op, logic [OPERAND_W-1:0] a_dig, logic [LEN_W-1:0] a_n,
                             logic [OPERAND_W-1:0] b_dig, logic [LEN_W-1:0] b_n);
        int gap;
        start    <= 1'b1;
        opcode   <= op;
        a_digits <= a_dig;
        a_len    <= a_n;
        b_digits <= b_dig;
        b_len    <= b_n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(6, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (checker_h.awaited_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [OPERAND_W-1:0] a_dig;
        logic [OPERAND_W-1:0] b_dig;
        logic [LEN_W-1:0]     a_n;
        logic [LEN_W-1:0]     b_n;
        int                   phase_pct[4];
        int                   tail;

        phase_pct = '{0, 61, 0, 16};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_word(OP_ADD, '0, 4'd0, '0, 4'd0);
        send_word(OP_ADD, to_digits(999999999), 4'd9, to_digits(999999999), 4'd9);
        send_word(OP_ADD, '1, 4'd9, '1, 4'd9);                 // raw nibbles, sum wraps negative
        send_word(OP_ADD, to_digits(1666666665), 4'd9, to_digits(480816983), 4'd9);
        send_word(OP_SUB, to_digits(12), 4'd2, to_digits(999999999), 4'd9);
        send_word(OP_SUB, to_digits(5), 4'd1, to_digits(5), 4'd1);
        send_word(OP_SUB, '0, 4'd0, '1, 4'd15);                // count saturates
        send_word(OP_MUL, to_digits(65536), 4'd5, to_digits(32768), 4'd5); // most negative value
        send_word(OP_MUL, to_digits(999999999), 4'd9, to_digits(999999999), 4'd9);
        send_word(OP_MUL, '1, 4'd12, to_digits(7), 4'd1);
        send_word(OP_MUL, to_digits(123456789), 4'd9, '0, 4'd9);
        send_word(OP_DIV, to_digits(123456789), 4'd9, '0, 4'd0); // zero divisor by count
        send_word(OP_DIV, to_digits(42), 4'd2, '0, 4'd9);        // zero divisor by digits
        send_word(OP_DIV, '1, 4'd9, to_digits(7), 4'd1);
        send_word(OP_DIV, to_digits(3), 4'd1, to_digits(999), 4'd3);
        send_word(OP_DIV, to_digits(999999999), 4'd9, to_digits(1), 4'd1);
        send_word(OP_DIV, 36'hFFFFFF123, 4'd3, 36'hFFFFFFF45, 4'd2); // digits above the count ignored
        send_word(OP_ADD, 36'hABCDEF012, 4'd10, 36'h000000FFF, 4'd3);
        send_word(OP_SUB, '0, 4'd0, 36'h0000000AF, 4'd2);
        send_word(OP_DIV, '0, 4'd0, to_digits(9), 4'd1);
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_pct[ph];
            for (int n = 0; n < RAND_WORDS / 4; n++)
            begin
                pick_operand(a_dig, a_n);
                pick_operand(b_dig, b_n);
                send_word(op_t'($urandom_range(3)), a_dig, a_n, b_dig, b_n);
            end
            drain_results();
        end

        tail = 0;
        while (tail < TAIL_CYCLES)
        begin
            @(posedge clk);
            tail++;
        end

        if (checker_h.errors == 0 && checker_h.awaited_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/dda_pkg.sv
hdl/dda_addsub.sv
hdl/decimal_digit_alu.sv
test/tb_top.sv
